// File: hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

   // Default number of cache slots
   localparam int ENTRIES_DEFAULT = 16;

   // Field widths
   localparam int DATA_W = 32;
   localparam int CFG_W  = 5;
   localparam int CSR_W  = 32;
   localparam int ADDR_W = 3;

   // Reset value of the entries_in_use register
   localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RESET = 5'd16;

   // Register index of entries_in_use
   localparam logic [0:0] CSR_IDX_ENTRIES = 1'b0;

   // Command codes
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // Read value returned on a miss or a put
   localparam logic [DATA_W-1:0] READ_MISS = '1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

// File: hw/rtl/lru_key_value_cache.sv
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser: cmd; tdata: lookup_key, store_value
// rsp       out  rsp_tvalid/rsp_tready  tuser: hit; tdata: read_value, newest_value
// csr       in   APB, pready always 1   entries_in_use at byte address 0
//
// One request at a time. A get miss takes only the search walk; a get hit or
// any put takes both walks: one key/rank compare unit walks the entry
// memories one slot per cycle, once to search and once more
// to age the recency ranks. A result waits in the output register while the
// next request runs; that request holds in its last step until the register
// drains. Reset (synchronous) clears the valid bits and the fill count at once.
module lru_key_value_cache #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*lkvc_pkg::DATA_W-1:0]     req_tdata,   // [31:0] lookup_key, [63:32] store_value
   input  logic                              req_tuser,   // [0] cmd
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [2*lkvc_pkg::DATA_W-1:0]     rsp_tdata,   // [31:0] read_value, [63:32] newest_value
   output logic                              rsp_tuser,   // [0] hit
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lkvc_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [lkvc_pkg::CSR_W-1:0]        csr_pwdata,
   output logic [lkvc_pkg::CSR_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   localparam int DW   = lkvc_pkg::DATA_W;
   localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int RW   = IDXW;
   localparam int CAPW = (CW > lkvc_pkg::CFG_W) ? CW : lkvc_pkg::CFG_W;

   // Entry storage
   logic [DW-1:0] key_mem  [ENTRIES];
   logic [DW-1:0] val_mem  [ENTRIES];
   logic [RW-1:0] rank_mem [ENTRIES];

   lkvc_pkg::state_type state_ff, state_in;

   logic [lkvc_pkg::CFG_W-1:0] eiu_ff, eiu_in;
   logic [ENTRIES-1:0]         valid_ff, valid_in;
   logic [CW-1:0]              filled_ff, filled_in;

   // Latched request
   logic          cmd_ff;
   logic [DW-1:0] key_ff, sval_ff;

   // Scan counter and read pipeline
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            pipe_vld_ff, pipe_vld_in;
   logic [IDXW-1:0] pipe_idx_ff, pipe_idx_in;
   logic [DW-1:0]   key_rd_ff, val_rd_ff;
   logic [RW-1:0]   rank_rd_ff;

   // Search results
   logic            match_ff, match_in;
   logic [IDXW-1:0] match_idx_ff, match_idx_in;
   logic [RW-1:0]   match_rank_ff, match_rank_in;
   logic [DW-1:0]   match_val_ff, match_val_in;
   logic            old_found_ff, old_found_in;
   logic [IDXW-1:0] old_idx_ff, old_idx_in;
   logic [RW-1:0]   old_rank_ff, old_rank_in;
   logic            free_found_ff, free_found_in;
   logic [IDXW-1:0] free_idx_ff, free_idx_in;
   logic [DW-1:0]   front_val_ff, front_val_in;

   // Update control and result
   logic            upd_insert_ff, upd_insert_in;
   logic [IDXW-1:0] upd_target_ff, upd_target_in;
   logic [RW-1:0]   upd_limit_ff, upd_limit_in;
   logic            res_hit_ff, res_hit_in;
   logic [DW-1:0]   res_read_ff, res_read_in;
   logic [DW-1:0]   res_newest_ff, res_newest_in;

   // Output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_hit_ff;
   logic [DW-1:0] rsp_read_ff, rsp_newest_ff;

   logic            req_acc;
   logic            issue;
   logic            last_proc;
   logic            cur_valid;
   logic            rsp_load;
   logic            csr_wr;
   logic [CAPW-1:0] eiu_ext, cap;
   logic            evict;
   logic [IDXW-1:0] slot;
   logic            mem_wr;
   logic [IDXW-1:0] mem_wr_idx;
   logic [DW-1:0]   mem_wr_val;
   logic            rank_wr;
   logic [RW-1:0]   rank_new;

   assign req_acc   = req_tvalid && req_tready;
   assign issue     = (state_ff == lkvc_pkg::ST_SCAN || state_ff == lkvc_pkg::ST_UPDATE)
                      && (cnt_ff < CW'(ENTRIES));
   assign last_proc = pipe_vld_ff && (cnt_ff == CW'(ENTRIES));
   assign cur_valid = valid_ff[pipe_idx_ff];
   assign rsp_load  = (state_ff == lkvc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Effective capacity: zero acts as one, clamp to the slot count
   always_comb begin
      eiu_ext = CAPW'(eiu_ff);
      if (eiu_ff == '0) begin
         cap = CAPW'(1);
      end else if (eiu_ext > CAPW'(ENTRIES)) begin
         cap = CAPW'(ENTRIES);
      end else begin
         cap = eiu_ext;
      end
      evict = (CAPW'(filled_ff) >= cap);
      if (evict && (!free_found_ff || old_idx_ff < free_idx_ff)) begin
         slot = old_idx_ff;
      end else begin
         slot = free_idx_ff;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (req_acc) state_in = lkvc_pkg::ST_SCAN;
         end
         lkvc_pkg::ST_SCAN: begin
            if (last_proc) state_in = lkvc_pkg::ST_DECIDE;
         end
         lkvc_pkg::ST_DECIDE: begin
            if (cmd_ff == lkvc_pkg::CMD_GET && !match_ff) begin
               state_in = lkvc_pkg::ST_DONE;
            end else begin
               state_in = lkvc_pkg::ST_UPDATE;
            end
         end
         lkvc_pkg::ST_UPDATE: begin
            if (last_proc) state_in = lkvc_pkg::ST_DONE;
         end
         lkvc_pkg::ST_DONE: begin
            if (rsp_load) state_in = lkvc_pkg::ST_IDLE;
         end
         default: state_in = lkvc_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_tready = 1'b0;
      case (state_ff)
         lkvc_pkg::ST_IDLE: req_tready = 1'b1;
         default:           req_tready = 1'b0;
      endcase
   end

   // Walk counter and read pipeline
   always_comb begin
      cnt_in      = cnt_ff;
      pipe_vld_in = issue;
      pipe_idx_in = cnt_ff[IDXW-1:0];
      if (state_ff == lkvc_pkg::ST_IDLE || state_ff == lkvc_pkg::ST_DECIDE) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   // Search pass: match, oldest, first free slot, current front
   always_comb begin
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      match_rank_in = match_rank_ff;
      match_val_in  = match_val_ff;
      old_found_in  = old_found_ff;
      old_idx_in    = old_idx_ff;
      old_rank_in   = old_rank_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      front_val_in  = front_val_ff;
      if (req_acc) begin
         match_in      = 1'b0;
         old_found_in  = 1'b0;
         free_found_in = 1'b0;
         front_val_in  = '0;
      end else if (state_ff == lkvc_pkg::ST_SCAN && pipe_vld_ff) begin
         if (cur_valid && key_rd_ff == key_ff && !match_ff) begin
            match_in      = 1'b1;
            match_idx_in  = pipe_idx_ff;
            match_rank_in = rank_rd_ff;
            match_val_in  = val_rd_ff;
         end
         if (cur_valid && (!old_found_ff || rank_rd_ff > old_rank_ff)) begin
            old_found_in = 1'b1;
            old_idx_in   = pipe_idx_ff;
            old_rank_in  = rank_rd_ff;
         end
         if (!cur_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = pipe_idx_ff;
         end
         if (cur_valid && rank_rd_ff == '0) begin
            front_val_in = val_rd_ff;
         end
      end
   end

   // Decide: result, entry write, valid and fill bookkeeping
   always_comb begin
      upd_insert_in = upd_insert_ff;
      upd_target_in = upd_target_ff;
      upd_limit_in  = upd_limit_ff;
      res_hit_in    = res_hit_ff;
      res_read_in   = res_read_ff;
      res_newest_in = res_newest_ff;
      valid_in      = valid_ff;
      filled_in     = filled_ff;
      mem_wr        = 1'b0;
      mem_wr_idx    = slot;
      mem_wr_val    = sval_ff;
      if (state_ff == lkvc_pkg::ST_DECIDE) begin
         res_hit_in    = 1'b0;
         res_read_in   = lkvc_pkg::READ_MISS;
         upd_insert_in = 1'b0;
         upd_target_in = match_idx_ff;
         upd_limit_in  = match_rank_ff;
         if (cmd_ff == lkvc_pkg::CMD_GET) begin
            if (match_ff) begin
               res_hit_in    = 1'b1;
               res_read_in   = match_val_ff;
               res_newest_in = match_val_ff;
            end else begin
               res_newest_in = front_val_ff;
            end
         end else begin
            res_newest_in = sval_ff;
            mem_wr        = 1'b1;
            if (match_ff) begin
               mem_wr_idx = match_idx_ff;
            end else begin
               // drop the oldest entry when full, then claim the slot
               upd_insert_in = 1'b1;
               upd_target_in = slot;
               if (evict) valid_in[old_idx_ff] = 1'b0;
               valid_in[slot] = 1'b1;
               filled_in = filled_ff + CW'(1) - CW'(evict);
            end
         end
      end
   end

   // Age pass: new rank of the entry leaving the read pipeline
   always_comb begin
      rank_wr = (state_ff == lkvc_pkg::ST_UPDATE) && pipe_vld_ff;
      if (pipe_idx_ff == upd_target_ff) begin
         rank_new = '0;
      end else if (cur_valid && (upd_insert_ff || rank_rd_ff < upd_limit_ff)) begin
         rank_new = rank_rd_ff + RW'(1);
      end else begin
         rank_new = rank_rd_ff;
      end
   end

   // Output register
   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || rsp_load;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser    = rsp_hit_ff;
   assign rsp_tdata    = {rsp_newest_ff, rsp_read_ff};

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      eiu_in = eiu_ff;
      if (csr_wr && csr_paddr[2:2] == lkvc_pkg::CSR_IDX_ENTRIES) begin
         eiu_in = csr_pwdata[lkvc_pkg::CFG_W-1:0];
      end
      if (csr_paddr[2:2] == lkvc_pkg::CSR_IDX_ENTRIES) begin
         csr_prdata = lkvc_pkg::CSR_W'(eiu_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvc_pkg::ST_IDLE;
         eiu_ff       <= lkvc_pkg::ENTRIES_IN_USE_RESET;
         valid_ff     <= '0;
         filled_ff    <= '0;
         cnt_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eiu_ff       <= eiu_in;
         valid_ff     <= valid_in;
         filled_ff    <= filled_in;
         cnt_ff       <= cnt_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff  <= req_tuser;
         key_ff  <= req_tdata[DW-1:0];
         sval_ff <= req_tdata[2*DW-1:DW];
      end
      pipe_idx_ff   <= pipe_idx_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      match_rank_ff <= match_rank_in;
      match_val_ff  <= match_val_in;
      old_found_ff  <= old_found_in;
      old_idx_ff    <= old_idx_in;
      old_rank_ff   <= old_rank_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      front_val_ff  <= front_val_in;
      upd_insert_ff <= upd_insert_in;
      upd_target_ff <= upd_target_in;
      upd_limit_ff  <= upd_limit_in;
      res_hit_ff    <= res_hit_in;
      res_read_ff   <= res_read_in;
      res_newest_ff <= res_newest_in;
      if (rsp_load) begin
         rsp_hit_ff    <= res_hit_ff;
         rsp_read_ff   <= res_read_ff;
         rsp_newest_ff <= res_newest_ff;
      end
   end

   // Entry memories: one registered read, one write each
   always_ff @(posedge clock) begin
      if (issue) begin
         key_rd_ff  <= key_mem[cnt_ff[IDXW-1:0]];
         val_rd_ff  <= val_mem[cnt_ff[IDXW-1:0]];
         rank_rd_ff <= rank_mem[cnt_ff[IDXW-1:0]];
      end
      if (mem_wr) begin
         key_mem[mem_wr_idx] <= key_ff;
         val_mem[mem_wr_idx] <= mem_wr_val;
      end
      if (rank_wr) begin
         rank_mem[pipe_idx_ff] <= rank_new;
      end
   end

   // Valid marks and fill count agree whenever no request is in flight
   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == lkvc_pkg::ST_IDLE |-> $countones(valid_ff) == int'(filled_ff))
      else $error("fill count does not match valid marks");

   // Fill level never exceeds the slot count
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CW'(ENTRIES))
      else $error("fill count above slot count");

   // A result without hit carries the miss value
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[DW-1:0] == lkvc_pkg::READ_MISS)
      else $error("miss or put result with wrong read value");

   // An accepted request starts the search walk from slot zero
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == lkvc_pkg::ST_SCAN && cnt_ff == '0)
      else $error("search walk did not start after request");

endmodule

// File: dv/lru_key_value_cache_tb.sv
module lru_key_value_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W          = lkvc_pkg::DATA_W;
   localparam int CFG_W           = lkvc_pkg::CFG_W;
   localparam int CSR_W           = lkvc_pkg::CSR_W;
   localparam int ADDR_W          = lkvc_pkg::ADDR_W;
   localparam int SLOTS           = lkvc_pkg::ENTRIES_DEFAULT;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = 2*SLOTS + 8;
   localparam int PLAN_ROWS       = 27;
   localparam int PHASES          = 11;

   // Capacity settings walked by the random part, extremes and out-of-range values included
   localparam int CAPACITY_PLAN [PHASES] = '{16, 3, 0, 31, 1, 8, 17, 2, 16, 5, 12};
   localparam logic [DATA_W-1:0] EDGE_KEYS [4] =
      '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
      logic [DATA_W-1:0] newest_value;
   } reply_type;

   typedef enum logic {ROW_REQUEST, ROW_CSR} row_kind_type;

   // For ROW_CSR rows the key column holds the byte address and the value column the data
   typedef struct packed {
      row_kind_type      kind;
      logic              cmd;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic              known;
      logic              hit;
      logic [DATA_W-1:0] exp_read;
      logic [DATA_W-1:0] exp_newest;
   } plan_row_type;

   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // empty cache: misses report an empty newest value
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0,
        lkvc_pkg::READ_MISS, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0,
        lkvc_pkg::READ_MISS, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0,
        lkvc_pkg::READ_MISS, 32'h7FFF_FFFF},
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1,
        32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{ROW_REQUEST, lkvc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b0,
        lkvc_pkg::READ_MISS, 32'h8000_0000},
      // update of an existing key moves it to the front
      '{ROW_REQUEST, lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0,
        lkvc_pkg::READ_MISS, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1,
        32'h8000_0000, 32'h8000_0000},
      '{ROW_REQUEST, lkvc_pkg::CMD_PUT, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b0,
        lkvc_pkg::READ_MISS, 32'hFFFF_FFFF},
      // capacity zero acts as one, and lies below the current fill
      '{ROW_CSR, lkvc_pkg::CMD_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_PUT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0,
        32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0},
      // write to an unmapped register index is dropped
      '{ROW_CSR, lkvc_pkg::CMD_GET, 32'h4, 32'hFFFF_FFF0, 1'b0, 1'b0, 32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_PUT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0,
        32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0},
      // capacity above the slot count acts as the slot count
      '{ROW_CSR, lkvc_pkg::CMD_GET, 32'h0, 32'd31, 1'b0, 1'b0, 32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_PUT, 32'h0000_0002, 32'h0000_0002, 1'b0, 1'b0,
        32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_PUT, 32'h0000_0003, 32'h0000_0003, 1'b0, 1'b0,
        32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'h0000_0003, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0},
      '{ROW_CSR, lkvc_pkg::CMD_GET, 32'h0, 32'd1, 1'b0, 1'b0, 32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_PUT, 32'h1357_9BDF, 32'h2468_ACE0, 1'b0, 1'b0,
        32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'h1357_9BDF, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0},
      '{ROW_CSR, lkvc_pkg::CMD_GET, 32'h0, 32'd16, 1'b0, 1'b0, 32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0},
      '{ROW_REQUEST, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [2*DATA_W-1:0]   req_tdata;   // [31:0] lookup_key, [63:32] store_value
   logic                  req_tuser;   // [0] cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [2*DATA_W-1:0]   rsp_tdata;   // [31:0] read_value, [63:32] newest_value
   logic                  rsp_tuser;   // [0] hit
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [ADDR_W-1:0]     csr_paddr;
   logic [CSR_W-1:0]      csr_pwdata;
   logic [CSR_W-1:0]      csr_prdata;
   logic                  csr_pready;

   // Shadow copy of the cache contents and the capacity register
   logic [DATA_W-1:0]     slot_key   [SLOTS];
   logic [DATA_W-1:0]     slot_value [SLOTS];
   logic                  slot_valid [SLOTS];
   int unsigned           slot_rank  [SLOTS];
   int unsigned           fill_level;
   logic [CFG_W-1:0]      capacity_reg;

   reply_type             replies_due [$];
   int                    mismatch_count;
   int                    cycle_count;
   bit                    send_burst;
   bit                    sink_burst;

   lru_key_value_cache #(
      .ENTRIES (SLOTS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Make slot s the most recent; valid entries newer than it age by one
   function automatic void promote_slot(int s);
      int unsigned r;
      r = slot_rank[s];
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
      slot_rank[s] = 0;
   endfunction

   // Place a new pair, evicting the least recent entry once the fill reaches capacity
   function automatic void insert_pair(logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
      int unsigned limit;
      int          oldest;
      int          slot;
      limit = capacity_reg;
      if (limit == 0) limit = 1;
      if (limit > SLOTS) limit = SLOTS;
      if (fill_level >= limit) begin
         oldest = -1;
         for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest])) oldest = i;
         if (oldest >= 0) begin
            slot_valid[oldest] = 1'b0;
            fill_level--;
         end
      end
      slot = -1;
      for (int i = 0; i < SLOTS; i++)
         if (!slot_valid[i] && slot < 0) slot = i;
      if (slot >= 0) begin
         for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i]) slot_rank[i]++;
         slot_key[slot]   = key;
         slot_value[slot] = value;
         slot_valid[slot] = 1'b1;
         slot_rank[slot]  = 0;
         fill_level++;
      end
   endfunction

   // Apply one request to the shadow cache and return the reply it must produce
   function automatic reply_type predict_access(logic cmd, logic [DATA_W-1:0] key,
                                                logic [DATA_W-1:0] value);
      reply_type r;
      int        found;
      found = -1;
      for (int i = 0; i < SLOTS; i++)
         if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
      r.hit          = 1'b0;
      r.read_value   = lkvc_pkg::READ_MISS;
      r.newest_value = '0;
      if (cmd == lkvc_pkg::CMD_GET) begin
         if (found >= 0) begin
            r.hit        = 1'b1;
            r.read_value = slot_value[found];
            promote_slot(found);
         end
      end else if (found >= 0) begin
         slot_value[found] = value;
         promote_slot(found);
      end else begin
         insert_pair(key, value);
      end
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_rank[i] == 0) r.newest_value = slot_value[i];
      return r;
   endfunction

   // Issue one request after a random gap and queue its expected reply on acceptance
   task automatic send_request(logic cmd, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value,
                               logic typed, reply_type typed_reply);
      int        gap;
      reply_type predicted;
      gap = send_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {value, key};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      predicted = predict_access(cmd, key, value);
      replies_due.push_back(typed ? typed_reply : predicted);
   endtask

   // Hold off new requests until every reply is back
   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   // Write a register, then read back entries_in_use in the same select
   task automatic write_csr(logic [ADDR_W-1:0] addr, logic [CSR_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr[ADDR_W-1:2] == lkvc_pkg::CSR_IDX_ENTRIES) capacity_reg = data[CFG_W-1:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {lkvc_pkg::CSR_IDX_ENTRIES, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_W'(capacity_reg)) begin
         $display("%0t: entries_in_use readback expected %h actual %h",
                  $realtime, CSR_W'(capacity_reg), csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Accept replies with random stalls and compare each against the oldest expectation
   initial begin : reply_sink
      int        stall;
      reply_type got;
      reply_type want;
      rsp_tready = 1'b0;
      sink_burst = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 49) == 0) sink_burst = !sink_burst;
         stall = sink_burst ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.hit          = rsp_tuser;
         got.read_value   = rsp_tdata[DATA_W-1:0];
         got.newest_value = rsp_tdata[2*DATA_W-1:DATA_W];
         if (replies_due.size() == 0) begin
            $display("%0t: reply expected none actual %h", $realtime, got);
            mismatch_count++;
         end else begin
            want = replies_due.pop_front();
            if (got.hit !== want.hit) begin
               $display("%0t: hit expected %b actual %b", $realtime, want.hit, got.hit);
               mismatch_count++;
            end
            if (got.read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h",
                        $realtime, want.read_value, got.read_value);
               mismatch_count++;
            end
            if (got.newest_value !== want.newest_value) begin
               $display("%0t: newest_value expected %h actual %h",
                        $realtime, want.newest_value, got.newest_value);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      plan_row_type      row;
      reply_type         typed;
      logic [DATA_W-1:0] key_pool [$];
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic [CSR_W-1:0]  cap_word;
      int                pool_size;
      int                cap;

      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = lkvc_pkg::CMD_GET;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      reset          = 1'b1;
      send_burst     = 1'b0;
      mismatch_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_valid[i] = 1'b0;
         slot_rank[i]  = 0;
      end
      fill_level   = 0;
      capacity_reg = lkvc_pkg::ENTRIES_IN_USE_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: walk the plan, register writes only once the cache is idle
      for (int n = 0; n < PLAN_ROWS; n++) begin
         row = DIRECTED_PLAN[n];
         if (row.kind == ROW_CSR) begin
            drain_requests();
            write_csr(row.key[ADDR_W-1:0], row.value);
         end else begin
            typed.hit          = row.hit;
            typed.read_value   = row.exp_read;
            typed.newest_value = row.exp_newest;
            send_request(row.cmd, row.key, row.value, row.known, typed);
         end
      end

      // Random part: one capacity setting per phase, keys drawn mostly from a small pool
      for (int p = 0; p < PHASES; p++) begin
         drain_requests();
         cap = CAPACITY_PLAN[p];
         cap_word = $urandom_range(0, 1) ? ($urandom() & ~32'h1F) : '0;
         write_csr({lkvc_pkg::CSR_IDX_ENTRIES, 2'b00}, cap_word | CSR_W'(cap));
         if ($urandom_range(0, 3) == 0) write_csr(ADDR_W'(4), $urandom());
         pool_size = $urandom_range(2, 10) + (cap > SLOTS ? SLOTS : cap);
         key_pool.delete();
         repeat (pool_size)
            key_pool.push_back($urandom_range(0, 9) == 0 ? EDGE_KEYS[$urandom_range(0, 3)]
                                                         : $urandom());
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
            key   = $urandom_range(0, 9) == 0 ? $urandom()
                                              : key_pool[$urandom_range(0, pool_size - 1)];
            value = $urandom_range(0, 7) == 0 ? lkvc_pkg::READ_MISS : $urandom();
            typed = '0;
            send_request($urandom_range(0, 1) ? lkvc_pkg::CMD_PUT : lkvc_pkg::CMD_GET,
                         key, value, 1'b0, typed);
         end
      end

      // Wait out the last replies plus one worst-case request time
      drain_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lru_key_value_cache.sv
dv/lru_key_value_cache_tb.sv
